@@ rtl/core/lsrc_pkg.sv @@
// Shared constants and types for the line segment rectangle clipper.
// No dependencies; compiled first.
package lsrc_pkg;

   // Register index of the control/status port
   typedef logic [1:0] csr_idx_type;

   localparam csr_idx_type CSR_CLIP_MIN_X = 2'd0;
   localparam csr_idx_type CSR_CLIP_MIN_Y = 2'd1;
   localparam csr_idx_type CSR_CLIP_MAX_X = 2'd2;
   localparam csr_idx_type CSR_CLIP_MAX_Y = 2'd3;

   // Edge tests in evaluation order
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_BOTTOM = 2;
   localparam int EDGE_TOP    = 3;
   localparam int NUM_EDGES   = 4;

   // Per-edge flags carried down the pipeline
   typedef struct packed {
      logic [NUM_EDGES-1:0] p_neg;
      logic [NUM_EDGES-1:0] p_zero;
      logic [NUM_EDGES-1:0] q_neg;
   } edge_flags_type;

endpackage

@@ rtl/core/lsrc_if.sv @@
// Valid/ready channel interfaces for segment words and clip result words.
// Depends on nothing; compiled after lsrc_pkg.
interface lsrc_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsrc_rsp_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic                         visible;
   logic signed [COORD_BITS-1:0] clipped_start_x;
   logic signed [COORD_BITS-1:0] clipped_start_y;
   logic signed [COORD_BITS-1:0] clipped_end_x;
   logic signed [COORD_BITS-1:0] clipped_end_y;

   modport source (output valid, visible, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, input ready);
   modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, output ready);
endinterface

@@ rtl/core/lsrc_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, ratio saturated to 2.
// Standalone; instantiated by line_segment_rect_clipper.
module lsrc_div #(
   parameter int NUM_BITS  = 33,
   parameter int FRAC_BITS = 24
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [NUM_BITS-1:0]  num,
   input  logic [NUM_BITS-1:0]  den,
   output logic [FRAC_BITS+1:0] ratio
);

   localparam int RW = NUM_BITS + 1;

   logic [RW-1:0]        rem_ff [0:FRAC_BITS];
   logic [NUM_BITS-1:0]  den_ff [0:FRAC_BITS];
   logic [FRAC_BITS:0]   quo_ff [0:FRAC_BITS];
   logic                 sat_ff [0:FRAC_BITS];

   genvar k;
   generate
      for (k = 0; k <= FRAC_BITS; k++) begin : g_stage
         if (k == 0) begin : g_first
            // integer bit and saturation check
            logic ge1, ge2;
            assign ge1 = (num >= den);
            assign ge2 = ({1'b0, num} >= {den, 1'b0});
            always_ff @(posedge clock) begin
               if (enable) begin
                  rem_ff[0] <= ge1 ? {1'b0, num - den} : {1'b0, num};
                  den_ff[0] <= den;
                  quo_ff[0] <= {{FRAC_BITS{1'b0}}, ge1};
                  sat_ff[0] <= ge2;
               end
            end
         end else begin : g_frac
            // one fraction bit
            logic [RW-1:0] shifted;
            logic          ge;
            assign shifted = {rem_ff[k-1][RW-2:0], 1'b0};
            assign ge      = (shifted >= {1'b0, den_ff[k-1]});
            always_ff @(posedge clock) begin
               if (enable) begin
                  rem_ff[k] <= ge ? shifted - {1'b0, den_ff[k-1]} : shifted;
                  den_ff[k] <= den_ff[k-1];
                  quo_ff[k] <= {quo_ff[k-1][FRAC_BITS-1:0], ge};
                  sat_ff[k] <= sat_ff[k-1];
               end
            end
         end
      end
   endgenerate

   assign ratio = sat_ff[FRAC_BITS] ? {1'b1, {(FRAC_BITS+1){1'b0}}}
                                    : {1'b0, quo_ff[FRAC_BITS]};

endmodule

@@ rtl/core/line_segment_rect_clipper.sv @@
// Liang-Barsky segment clipper against a configured rectangle, signed Q24.8.
// Every stage is registered and advances together; one word per cycle sustained,
// set by the bit-per-stage divider lanes. The whole pipeline holds while the
// result word waits. Synchronous reset clears valid bits and loads the default
// rectangle (0,0)-(1920,1080). Uses lsrc_pkg, lsrc_if, lsrc_div.
module line_segment_rect_clipper #(
   parameter int COORD_BITS       = 32,
   parameter int T_FRAC_BITS      = 24,
   parameter int CLIP_MAX_X_RESET = 491520,
   parameter int CLIP_MAX_Y_RESET = 276480
) (
   input  logic                     clock,
   input  logic                     reset,
   lsrc_req_if.sink                 req_ch,
   lsrc_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  lsrc_pkg::csr_idx_type    csr_index,
   input  logic [COORD_BITS-1:0]    csr_wdata
);
   import lsrc_pkg::*;

   localparam int CW = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int TW = T_FRAC_BITS;
   localparam int RW = TW + 2;       // ratio magnitude
   localparam int SW = TW + 3;       // signed ratio
   localparam int PW = TW + 1 + DW;  // product

   typedef struct packed {
      logic [CW-1:0]  ax;
      logic [CW-1:0]  ay;
      logic           dx_neg;
      logic           dy_neg;
      logic [DW-1:0]  mdx;
      logic [DW-1:0]  mdy;
      edge_flags_type flags;
   } side_type;

   typedef struct packed {
      side_type                 side;
      logic [NUM_EDGES-1:0][RW-1:0] ratio;
      logic [TW:0]              t0;
      logic [TW:0]              t1;
      logic                     ok;
   } edge_stage_type;

   // configuration registers
   logic [CW-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         min_y_ff <= '0;
         max_x_ff <= CW'(CLIP_MAX_X_RESET);
         max_y_ff <= CW'(CLIP_MAX_Y_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CLIP_MIN_X: min_x_ff <= csr_wdata;
            CSR_CLIP_MIN_Y: min_y_ff <= csr_wdata;
            CSR_CLIP_MAX_X: max_x_ff <= csr_wdata;
            CSR_CLIP_MAX_Y: max_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance the whole pipeline unless the result word is stalled
   logic advance;
   logic out_valid_ff;
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // stage 1: capture input word
   logic          s1_valid_ff;
   logic [CW-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= req_ch.valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ax_ff <= req_ch.start_x;
         s1_ay_ff <= req_ch.start_y;
         s1_bx_ff <= req_ch.end_x;
         s1_by_ff <= req_ch.end_y;
      end
   end

   // stage 2: direction and distance terms
   logic                 s2_valid_ff;
   logic [CW-1:0]        s2_ax_ff, s2_ay_ff;
   logic signed [DW-1:0] s2_dx_ff, s2_dy_ff;
   logic signed [DW-1:0] s2_q_ff [NUM_EDGES];

   function automatic logic signed [DW-1:0] sx(input logic [CW-1:0] v);
      return {v[CW-1], v};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ax_ff              <= s1_ax_ff;
         s2_ay_ff              <= s1_ay_ff;
         s2_dx_ff              <= sx(s1_bx_ff) - sx(s1_ax_ff);
         s2_dy_ff              <= sx(s1_by_ff) - sx(s1_ay_ff);
         s2_q_ff[EDGE_LEFT]    <= sx(s1_ax_ff) - sx(min_x_ff);
         s2_q_ff[EDGE_RIGHT]   <= sx(max_x_ff) - sx(s1_ax_ff);
         s2_q_ff[EDGE_BOTTOM]  <= sx(s1_ay_ff) - sx(min_y_ff);
         s2_q_ff[EDGE_TOP]     <= sx(max_y_ff) - sx(s1_ay_ff);
      end
   end

   // stage 3: magnitudes and sign flags
   logic          s3_valid_ff;
   side_type      s3_side_ff;
   logic [DW-1:0] s3_mq_ff [NUM_EDGES];
   side_type      s3_side_in;

   always_comb begin
      s3_side_in.ax     = s2_ax_ff;
      s3_side_in.ay     = s2_ay_ff;
      s3_side_in.dx_neg = s2_dx_ff[DW-1];
      s3_side_in.dy_neg = s2_dy_ff[DW-1];
      s3_side_in.mdx    = s2_dx_ff[DW-1] ? DW'(-s2_dx_ff) : DW'(s2_dx_ff);
      s3_side_in.mdy    = s2_dy_ff[DW-1] ? DW'(-s2_dy_ff) : DW'(s2_dy_ff);
      // left/bottom use -d, right/top use d
      s3_side_in.flags.p_neg[EDGE_LEFT]    = !s2_dx_ff[DW-1] && (s2_dx_ff != '0);
      s3_side_in.flags.p_neg[EDGE_RIGHT]   = s2_dx_ff[DW-1];
      s3_side_in.flags.p_neg[EDGE_BOTTOM]  = !s2_dy_ff[DW-1] && (s2_dy_ff != '0);
      s3_side_in.flags.p_neg[EDGE_TOP]     = s2_dy_ff[DW-1];
      s3_side_in.flags.p_zero[EDGE_LEFT]   = (s2_dx_ff == '0);
      s3_side_in.flags.p_zero[EDGE_RIGHT]  = (s2_dx_ff == '0);
      s3_side_in.flags.p_zero[EDGE_BOTTOM] = (s2_dy_ff == '0);
      s3_side_in.flags.p_zero[EDGE_TOP]    = (s2_dy_ff == '0);
      for (int i = 0; i < NUM_EDGES; i++) begin
         s3_side_in.flags.q_neg[i] = s2_q_ff[i][DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (advance) s3_valid_ff <= s2_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_side_ff <= s3_side_in;
         for (int i = 0; i < NUM_EDGES; i++) begin
            s3_mq_ff[i] <= s2_q_ff[i][DW-1] ? DW'(-s2_q_ff[i]) : DW'(s2_q_ff[i]);
         end
      end
   end

   // divider lanes, one per edge
   logic [NUM_EDGES-1:0][RW-1:0] div_ratio;

   genvar g;
   generate
      for (g = 0; g < NUM_EDGES; g++) begin : g_div
         lsrc_div #(
            .NUM_BITS  (DW),
            .FRAC_BITS (TW)
         ) u_div (
            .clock  (clock),
            .enable (advance),
            .num    (s3_mq_ff[g]),
            .den    ((g < EDGE_BOTTOM) ? s3_side_ff.mdx : s3_side_ff.mdy),
            .ratio  (div_ratio[g])
         );
      end
   endgenerate

   // side band runs beside the divider lanes
   logic     dv_valid_ff [0:TW];
   side_type dv_side_ff  [0:TW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= TW; i++) dv_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0] <= s3_valid_ff;
         for (int i = 1; i <= TW; i++) dv_valid_ff[i] <= dv_valid_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dv_side_ff[0] <= s3_side_ff;
         for (int i = 1; i <= TW; i++) dv_side_ff[i] <= dv_side_ff[i-1];
      end
   end

   // edge tests: one stage per edge, in order
   logic           ed_valid_ff [NUM_EDGES];
   edge_stage_type ed_ff       [NUM_EDGES];
   edge_stage_type ed_src      [NUM_EDGES];
   edge_stage_type ed_in       [NUM_EDGES];
   logic           ed_vsrc     [NUM_EDGES];

   always_comb begin
      ed_src[0].side  = dv_side_ff[TW];
      ed_src[0].ratio = div_ratio;
      ed_src[0].t0    = '0;
      ed_src[0].t1    = {1'b1, {TW{1'b0}}};
      ed_src[0].ok    = 1'b1;
      ed_vsrc[0]      = dv_valid_ff[TW];
      for (int i = 1; i < NUM_EDGES; i++) begin
         ed_src[i]  = ed_ff[i-1];
         ed_vsrc[i] = ed_valid_ff[i-1];
      end
   end

   generate
      for (g = 0; g < NUM_EDGES; g++) begin : g_edge
         logic signed [SW-1:0] r;
         logic signed [SW-1:0] t0s, t1s;
         logic                 pn, pz, qn;

         assign pn  = ed_src[g].side.flags.p_neg[g];
         assign pz  = ed_src[g].side.flags.p_zero[g];
         assign qn  = ed_src[g].side.flags.q_neg[g];
         assign r   = (pn != qn) ? -SW'(ed_src[g].ratio[g]) : SW'(ed_src[g].ratio[g]);
         assign t0s = SW'(ed_src[g].t0);
         assign t1s = SW'(ed_src[g].t1);

         // narrow the parameter interval or reject
         always_comb begin
            ed_in[g] = ed_src[g];
            if (ed_src[g].ok) begin
               priority if (pz) begin
                  ed_in[g].ok = !qn;
               end else if (pn) begin
                  if (r > t1s) ed_in[g].ok = 1'b0;
                  else if (r > t0s) ed_in[g].t0 = r[TW:0];
               end else begin
                  if (r < t0s) ed_in[g].ok = 1'b0;
                  else if (r < t1s) ed_in[g].t1 = r[TW:0];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) ed_valid_ff[g] <= 1'b0;
            else if (advance) ed_valid_ff[g] <= ed_vsrc[g];
         end
         always_ff @(posedge clock) begin
            if (advance) ed_ff[g] <= ed_in[g];
         end
      end
   endgenerate

   // multiply stage: t times |d| for each clipped coordinate
   localparam int LAST = NUM_EDGES - 1;
   logic          mu_valid_ff;
   logic          mu_ok_ff;
   logic [CW-1:0] mu_ax_ff, mu_ay_ff;
   logic          mu_dxn_ff, mu_dyn_ff;
   logic [PW-1:0] mu_prod_ff [4];

   always_ff @(posedge clock) begin
      if (reset) mu_valid_ff <= 1'b0;
      else if (advance) mu_valid_ff <= ed_valid_ff[LAST];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         mu_ok_ff      <= ed_ff[LAST].ok;
         mu_ax_ff      <= ed_ff[LAST].side.ax;
         mu_ay_ff      <= ed_ff[LAST].side.ay;
         mu_dxn_ff     <= ed_ff[LAST].side.dx_neg;
         mu_dyn_ff     <= ed_ff[LAST].side.dy_neg;
         mu_prod_ff[0] <= PW'(ed_ff[LAST].t0) * PW'(ed_ff[LAST].side.mdx);
         mu_prod_ff[1] <= PW'(ed_ff[LAST].t0) * PW'(ed_ff[LAST].side.mdy);
         mu_prod_ff[2] <= PW'(ed_ff[LAST].t1) * PW'(ed_ff[LAST].side.mdx);
         mu_prod_ff[3] <= PW'(ed_ff[LAST].t1) * PW'(ed_ff[LAST].side.mdy);
      end
   end

   // output stage: scale down, round toward minus infinity, offset from start
   function automatic logic [CW-1:0] place(input logic [CW-1:0] base,
                                           input logic [PW-1:0] prod,
                                           input logic          neg);
      logic [CW-1:0] v;
      logic          up;
      v  = prod[TW +: CW];
      up = neg && (prod[TW-1:0] != '0);
      return neg ? base - v - CW'(up) : base + v;
   endfunction

   logic          vis_ff;
   logic [CW-1:0] csx_ff, csy_ff, cex_ff, cey_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= mu_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         vis_ff <= mu_ok_ff;
         csx_ff <= mu_ok_ff ? place(mu_ax_ff, mu_prod_ff[0], mu_dxn_ff) : '0;
         csy_ff <= mu_ok_ff ? place(mu_ay_ff, mu_prod_ff[1], mu_dyn_ff) : '0;
         cex_ff <= mu_ok_ff ? place(mu_ax_ff, mu_prod_ff[2], mu_dxn_ff) : '0;
         cey_ff <= mu_ok_ff ? place(mu_ay_ff, mu_prod_ff[3], mu_dyn_ff) : '0;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.visible         = vis_ff;
   assign rsp_ch.clipped_start_x = csx_ff;
   assign rsp_ch.clipped_start_y = csy_ff;
   assign rsp_ch.clipped_end_x   = cex_ff;
   assign rsp_ch.clipped_end_y   = cey_ff;

endmodule
